// File: hw/rtl/bae_pkg.sv
// Shared types and constants for the binarize and 3x3 erode block.
`default_nettype none

package bae_pkg;

    // Frame geometry limits and derived widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration register widths.
    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int THR_W  = 8;
    localparam int MASK_W = 9;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Configuration reset values.
    localparam logic [FW_W-1:0]   FW_RESET   = 12'd640;
    localparam logic [FH_W-1:0]   FH_RESET   = 13'd480;
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd127;
    localparam logic [MASK_W-1:0] MASK_RESET = 9'd443;

    // Window shift keeps the left two columns; bits 2, 5 and 8 take new data.
    localparam logic [MASK_W-1:0] WIN_KEEP = 9'b011011011;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_THRESHOLD    = 2'd2,
        REG_ELEMENT_MASK = 2'd3
    } t_reg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [FW_W-1:0]   frame_width;
        logic [FH_W-1:0]   frame_height;
        logic [THR_W-1:0]  threshold;
        logic [MASK_W-1:0] element_mask;
    } t_cfg;

    // One pixel after the front stage: position, binary value and result flags.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cur;
        logic             emit_prev;   // previous row, previous column
        logic             emit_edge;   // previous row, last column
        logic             emit_cur;    // current pixel on top or bottom row
        logic             prev_inner;  // previous column is not the left border
    } t_item;

    // One result item.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             bin;
        logic             ero;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/binarize_and_erode_3x3.sv
// Top level of the binarize and 3x3 erode block.
//
// Pixels enter on the s_axis channel in raster order: tdata carries blue,
// green and red, tuser marks the first pixel of a frame. Each pixel is
// binarized against the threshold register and fed into two one-bit line
// memories and a 3x3 window. Results leave on m_axis: tdata carries the
// row, column, binary value and eroded value of one pixel, tlast marks the
// last result caused by an input pixel.
// A pixel is registered in the stage register and then turned into zero
// to three results, which are loaded into the result queue. One pixel is
// taken per cycle while it causes at most one result and the receiver
// takes every result; a pixel causing two or three results (at row ends,
// and on the last row) holds the input while the three-entry result queue
// drains, one result per cycle while the receiver is ready.
// When the receiver stalls, results wait in the queue and the input stops once
// the stage register holds a pixel that cannot be committed. Reset clears the
// counters, the window and the queue and loads the default geometry, threshold
// and mask; the line memories need no clearing. Configuration is written by the
// user through the cfg port only while idle; the block itself does not enforce this.
`default_nettype none

module binarize_and_erode_3x3 (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration writes.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [bae_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bae_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Pixel input.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: blue[7:0], green[15:8], red[23:16]
    input  wire logic [bae_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: frame_start[0]
    input  wire logic                             s_axis_tuser,
    // Result output.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: out_row[11:0], out_col[22:12], binary_white[23],
    //        eroded_white[24], zero[31:25]
    output logic [bae_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tlast
);

    bae_pkg::t_cfg             cfg;
    bae_pkg::t_item            s1_item;
    bae_pkg::t_result          result;
    logic                      s1_valid;
    logic                      accept;
    logic                      commit;
    logic [bae_pkg::COL_W-1:0] rd_addr;
    logic                      older;
    logic                      newer;

    bae_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bae_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data        (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_commit      (commit),
        .o_accept      (accept),
        .o_rd_addr     (rd_addr),
        .o_s1_valid    (s1_valid),
        .o_s1_item     (s1_item)
    );

    bae_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (commit),
        .i_wr_addr (s1_item.col),
        .i_wr_cur  (s1_item.cur),
        .o_older   (older),
        .o_newer   (newer)
    );

    bae_erode u_erode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mask     (cfg.element_mask),
        .i_s1_valid (s1_valid),
        .i_item     (s1_item),
        .i_older    (older),
        .i_newer    (newer),
        .o_commit   (commit),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    // Output packing.
    assign m_axis_tdata = {7'b0, result.ero, result.bin, result.col, result.row};
    assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

// File: hw/rtl/bae_cfg.sv
// Configuration registers of the binarize and erode block.
`default_nettype none

module bae_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bae_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bae_pkg::t_cfg                       o_cfg
);

    bae_pkg::t_cfg r_cfg;

    // Register writes, one register per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= bae_pkg::FW_RESET;
            r_cfg.frame_height <= bae_pkg::FH_RESET;
            r_cfg.threshold    <= bae_pkg::THR_RESET;
            r_cfg.element_mask <= bae_pkg::MASK_RESET;
        end else if (i_cfg_wr_en) begin
            case (bae_pkg::t_reg_idx'(i_cfg_index))
                bae_pkg::REG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data[bae_pkg::FW_W-1:0];
                end
                bae_pkg::REG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data[bae_pkg::FH_W-1:0];
                end
                bae_pkg::REG_THRESHOLD: begin
                    r_cfg.threshold <= i_cfg_data[bae_pkg::THR_W-1:0];
                end
                bae_pkg::REG_ELEMENT_MASK: begin
                    r_cfg.element_mask <= i_cfg_data[bae_pkg::MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/bae_front.sv
// Front stage: pixel counters, binarization and the stage register.
`default_nettype none

module bae_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bae_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [bae_pkg::IN_TDATA_W-1:0]  i_data,
    input  wire logic                            i_frame_start,
    input  wire logic                            i_commit,
    output logic                                 o_accept,
    output logic [bae_pkg::COL_W-1:0]            o_rd_addr,
    output logic                                 o_s1_valid,
    output bae_pkg::t_item                       o_s1_item
);

    logic [bae_pkg::COL_W-1:0] r_col;
    logic [bae_pkg::ROW_W-1:0] r_row;
    logic [bae_pkg::COL_W-1:0] n_col;
    logic [bae_pkg::ROW_W-1:0] n_row;
    logic                      r_s1_valid;
    bae_pkg::t_item            r_item;
    bae_pkg::t_item            n_item;

    logic [bae_pkg::FW_W-1:0]  w;
    logic [bae_pkg::FH_W-1:0]  h;
    logic [bae_pkg::FW_W-1:0]  col_s;
    logic [bae_pkg::FW_W-1:0]  col_a;
    logic [bae_pkg::FW_W-1:0]  col_b;
    logic [bae_pkg::FH_W-1:0]  row_s;
    logic [bae_pkg::FH_W-1:0]  row_a;
    logic [bae_pkg::FH_W-1:0]  row_b;
    logic [9:0]                sum;
    logic [9:0]                limit;

    // The stage register frees up whenever its item is committed downstream.
    assign o_ready  = !r_s1_valid || i_commit;
    assign o_accept = i_valid && o_ready;

    // Geometry clamping, position of the new pixel and counter advance.
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w = bae_pkg::FW_W'(1);
        end else if (i_cfg.frame_width > bae_pkg::FW_W'(bae_pkg::MAX_WIDTH)) begin
            w = bae_pkg::FW_W'(bae_pkg::MAX_WIDTH);
        end else begin
            w = i_cfg.frame_width;
        end
        if (i_cfg.frame_height == '0) begin
            h = bae_pkg::FH_W'(1);
        end else if (i_cfg.frame_height > bae_pkg::FH_W'(bae_pkg::MAX_HEIGHT)) begin
            h = bae_pkg::FH_W'(bae_pkg::MAX_HEIGHT);
        end else begin
            h = i_cfg.frame_height;
        end

        // A frame start restarts the counters.
        col_s = i_frame_start ? '0 : bae_pkg::FW_W'(r_col);
        row_s = i_frame_start ? '0 : bae_pkg::FH_W'(r_row);

        // Counters left beyond a shrunk geometry wrap first.
        if (col_s >= w) begin
            col_a = '0;
            row_a = row_s + bae_pkg::FH_W'(1);
        end else begin
            col_a = col_s;
            row_a = row_s;
        end
        if (row_a >= h) begin
            row_a = '0;
        end

        // Binarize: mean above threshold means white, i.e. sum > 3*thr + 2.
        sum   = 10'(i_data[7:0]) + 10'(i_data[15:8]) + 10'(i_data[23:16]);
        limit = {1'b0, i_cfg.threshold, 1'b0} + 10'(i_cfg.threshold) + 10'd2;

        n_item.row        = row_a[bae_pkg::ROW_W-1:0];
        n_item.col        = col_a[bae_pkg::COL_W-1:0];
        n_item.cur        = (sum > limit);
        n_item.emit_prev  = (row_a >= bae_pkg::FH_W'(2)) && (col_a != '0);
        n_item.emit_edge  = (row_a >= bae_pkg::FH_W'(2)) &&
                            (col_a == w - bae_pkg::FW_W'(1));
        n_item.emit_cur   = (row_a == '0) || (row_a == h - bae_pkg::FH_W'(1));
        n_item.prev_inner = (col_a >= bae_pkg::FW_W'(2));

        // Advance to the next pixel position.
        col_b = col_a + bae_pkg::FW_W'(1);
        row_b = row_a;
        if (col_b >= w) begin
            col_b = '0;
            row_b = row_a + bae_pkg::FH_W'(1);
            if (row_b >= h) begin
                row_b = '0;
            end
        end
        n_col = col_b[bae_pkg::COL_W-1:0];
        n_row = row_b[bae_pkg::ROW_W-1:0];
    end

    // Counters and stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (o_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_item <= n_item;
        end
    end

    assign o_rd_addr  = n_item.col;
    assign o_s1_valid = r_s1_valid;
    assign o_s1_item  = r_item;

endmodule

`default_nettype wire

// File: hw/rtl/bae_line_buf.sv
// Two one-bit line memories holding the previous two binary rows.
`default_nettype none

module bae_line_buf (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [bae_pkg::COL_W-1:0] i_rd_addr,
    input  wire logic                      i_wr_en,
    input  wire logic [bae_pkg::COL_W-1:0] i_wr_addr,
    input  wire logic                      i_wr_cur,
    output logic                           o_older,
    output logic                           o_newer
);

    logic mem_older [bae_pkg::MAX_WIDTH];
    logic mem_newer [bae_pkg::MAX_WIDTH];
    logic r_older_rd;
    logic r_newer_rd;
    logic r_fwd;
    logic r_fwd_older;
    logic r_fwd_newer;

    // A write shifts the column down one row: newer moves to older.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_older[i_wr_addr] <= o_newer;
            mem_newer[i_wr_addr] <= i_wr_cur;
        end
    end

    // Registered read for the pixel entering the stage register.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_older_rd  <= mem_older[i_rd_addr];
            r_newer_rd  <= mem_newer[i_rd_addr];
            r_fwd_older <= o_newer;
            r_fwd_newer <= i_wr_cur;
        end
    end

    // A read that meets a write to the same column takes the written bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_older = r_fwd ? r_fwd_older : r_older_rd;
    assign o_newer = r_fwd ? r_fwd_newer : r_newer_rd;

endmodule

`default_nettype wire

// File: hw/rtl/bae_erode.sv
// 3x3 window, erosion results and the result queue that feeds the output.
`default_nettype none

module bae_erode (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [bae_pkg::MASK_W-1:0]  i_mask,
    input  wire logic                        i_s1_valid,
    input  wire bae_pkg::t_item              i_item,
    input  wire logic                        i_older,
    input  wire logic                        i_newer,
    output logic                             o_commit,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output bae_pkg::t_result                 o_result
);

    logic [bae_pkg::MASK_W-1:0] r_win;
    logic [bae_pkg::MASK_W-1:0] n_win;
    bae_pkg::t_result           r_q [3];
    logic [1:0]                 r_cnt;
    bae_pkg::t_result           ld [3];
    logic [1:0]                 ld_n;
    bae_pkg::t_result           e_prev;
    bae_pkg::t_result           e_edge;
    bae_pkg::t_result           e_cur;
    logic [1:0]                 pos_edge;
    logic                       pop;

    assign pop      = o_valid && i_ready;
    // A new item goes in only when the queue will be empty after this cycle.
    assign o_commit = i_s1_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));

    // Window update and the up to three results of this pixel.
    always_comb begin
        n_win = ((r_win >> 1) & bae_pkg::WIN_KEEP) |
                {i_item.cur, 2'b00, i_newer, 2'b00, i_older, 2'b00};

        e_prev.row  = i_item.row - bae_pkg::ROW_W'(1);
        e_prev.col  = i_item.col - bae_pkg::COL_W'(1);
        e_prev.bin  = n_win[4];
        e_prev.ero  = i_item.prev_inner ? ((i_mask & ~n_win) == '0) : n_win[4];
        e_prev.last = !i_item.emit_edge && !i_item.emit_cur;

        e_edge.row  = i_item.row - bae_pkg::ROW_W'(1);
        e_edge.col  = i_item.col;
        e_edge.bin  = n_win[5];
        e_edge.ero  = n_win[5];
        e_edge.last = !i_item.emit_cur;

        e_cur.row   = i_item.row;
        e_cur.col   = i_item.col;
        e_cur.bin   = i_item.cur;
        e_cur.ero   = i_item.cur;
        e_cur.last  = 1'b1;

        // Pack the selected results in order into the load slots.
        pos_edge = {1'b0, i_item.emit_prev};
        ld_n     = 2'(i_item.emit_prev) + 2'(i_item.emit_edge) + 2'(i_item.emit_cur);
        for (int k = 0; k < 3; k++) begin
            if (i_item.emit_prev && (k == 0)) begin
                ld[k] = e_prev;
            end else if (i_item.emit_edge && (2'(k) == pos_edge)) begin
                ld[k] = e_edge;
            end else begin
                ld[k] = e_cur;
            end
        end
    end

    // Window register and queue count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_cnt <= 2'd0;
        end else if (o_commit) begin
            r_win <= n_win;
            r_cnt <= ld_n;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Queue payload: load on commit, otherwise shift toward the head on a pop.
    always_ff @(posedge i_clk) begin
        if (o_commit) begin
            r_q[0] <= ld[0];
            r_q[1] <= ld[1];
            r_q[2] <= ld[2];
        end else if (pop) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_q[0];

endmodule

`default_nettype wire

// File: verif/bae_result_checker.sv
// Result checker for the binarize and 3x3 erode block: bit-true prediction and comparison.
module bae_result_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration writes, as seen by the block.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [bae_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bae_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Pixel channel.
    input  wire logic                             i_pix_tvalid,
    input  wire logic                             i_pix_tready,
    // tdata: blue[7:0], green[15:8], red[23:16]
    input  wire logic [bae_pkg::IN_TDATA_W-1:0]   i_pix_tdata,
    // tuser: frame_start[0]
    input  wire logic                             i_pix_tuser,
    // Result channel.
    input  wire logic                             i_res_tvalid,
    input  wire logic                             i_res_tready,
    // tdata: out_row[11:0], out_col[22:12], binary_white[23],
    //        eroded_white[24], zero[31:25]
    input  wire logic [bae_pkg::OUT_TDATA_W-1:0]  i_res_tdata,
    input  wire logic                             i_res_tlast,
    output int                                    o_awaited,
    output int                                    o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import bae_pkg::*;

    // Copy of the configuration registers.
    logic [FW_W-1:0]   cfg_width;
    logic [FH_W-1:0]   cfg_height;
    logic [THR_W-1:0]  cfg_thresh;
    logic [MASK_W-1:0] cfg_mask;

    // Binary line memories, neighborhood window and raster position.
    bit                older_line [MAX_WIDTH];
    bit                newer_line [MAX_WIDTH];
    logic [MASK_W-1:0] window;
    int unsigned       col_cnt;
    int unsigned       row_cnt;

    // Pixel results that the block still owes, oldest first.
    t_result           awaited_pixels [$];
    int                mismatches = 0;

    assign o_mismatches = mismatches;

    initial o_awaited = 0;

    task automatic note_mismatch(input string msg);
        if (mismatches < 100)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_result make_result(input int unsigned row, input int unsigned col,
                                            input bit bin, input bit ero);
        t_result res;
        res.row  = ROW_W'(row);
        res.col  = COL_W'(col);
        res.bin  = bin;
        res.ero  = ero;
        res.last = 1'b0;
        return res;
    endfunction

    // Binarize one pixel, shift it into the window and work out the results it releases.
    task automatic take_pixel(input logic [IN_TDATA_W-1:0] rgb, input logic start);
        int unsigned w;
        int unsigned h;
        int unsigned mean;
        int          n;
        bit          cur;
        bit          ob;
        bit          nb;
        t_result     found [3];

        // Out-of-range geometry is clamped to what the memories hold.
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);

        if (start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // A geometry that shrank under a running frame moves the position on.
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h)
            row_cnt = 0;

        mean = (int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3;
        cur  = (mean > cfg_thresh);

        ob = older_line[col_cnt];
        nb = newer_line[col_cnt];
        window = ((window >> 1) & WIN_KEEP) | (MASK_W'(ob) << 2) | (MASK_W'(nb) << 5)
                 | (MASK_W'(cur) << 8);
        older_line[col_cnt] = nb;
        newer_line[col_cnt] = cur;

        n = 0;
        // Interior rows are reported one row late, one column behind.
        if (row_cnt >= 2 && row_cnt <= h - 1) begin
            if (col_cnt >= 1) begin
                if (col_cnt >= 2)
                    found[n] = make_result(row_cnt - 1, col_cnt - 1, window[4],
                                           (cfg_mask & ~window) == '0);
                else
                    found[n] = make_result(row_cnt - 1, col_cnt - 1, window[4], window[4]);
                n++;
            end
            if (col_cnt == w - 1) begin
                found[n] = make_result(row_cnt - 1, col_cnt, window[5], window[5]);
                n++;
            end
        end
        // Top and bottom rows pass straight through.
        if (row_cnt == 0 || row_cnt == h - 1) begin
            found[n] = make_result(row_cnt, col_cnt, cur, cur);
            n++;
        end

        for (int k = 0; k < n; k++) begin
            found[k].last = (k == n - 1);
            awaited_pixels.push_back(found[k]);
        end

        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endtask

    // Compare one delivered result with the oldest one owed.
    task automatic check_result(input logic [OUT_TDATA_W-1:0] data, input logic tlast);
        t_result want;
        if (awaited_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected result row %0d col %0d",
                                    data[11:0], data[22:12]));
            return;
        end
        want = awaited_pixels.pop_front();
        if (data[11:0] !== want.row)
            note_mismatch($sformatf("row %0d, wanted %0d", data[11:0], want.row));
        if (data[22:12] !== want.col)
            note_mismatch($sformatf("col %0d, wanted %0d (row %0d)",
                                    data[22:12], want.col, want.row));
        if (data[23] !== want.bin)
            note_mismatch($sformatf("binary %b, wanted %b at row %0d col %0d",
                                    data[23], want.bin, want.row, want.col));
        if (data[24] !== want.ero)
            note_mismatch($sformatf("eroded %b, wanted %b at row %0d col %0d",
                                    data[24], want.ero, want.row, want.col));
        if (tlast !== want.last)
            note_mismatch($sformatf("tlast %b, wanted %b at row %0d col %0d",
                                    tlast, want.last, want.row, want.col));
        if (data[31:25] !== '0)
            note_mismatch($sformatf("padding bits %b not zero", data[31:25]));
    endtask

    // Watch both channels and the configuration port on every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = FW_RESET;
            cfg_height = FH_RESET;
            cfg_thresh = THR_RESET;
            cfg_mask   = MASK_RESET;
            window     = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                older_line[k] = 1'b0;
                newer_line[k] = 1'b0;
            end
            awaited_pixels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_FRAME_WIDTH:  cfg_width  = i_cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height = i_cfg_data[FH_W-1:0];
                    REG_THRESHOLD:    cfg_thresh = i_cfg_data[THR_W-1:0];
                    REG_ELEMENT_MASK: cfg_mask   = i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_tvalid && i_pix_tready)
                take_pixel(i_pix_tdata, i_pix_tuser);
            if (i_res_tvalid && i_res_tready)
                check_result(i_res_tdata, i_res_tlast);
        end
        o_awaited <= awaited_pixels.size();
    end

endmodule

// File: verif/binarize_and_erode_3x3_test.sv
// Top of the binarize and 3x3 erode testbench: clock, reset, pixel stimulus and verdict.
module binarize_and_erode_3x3_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bae_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int RANDOM_PIXELS = 320;
    localparam int SETTLE_CYCLES = 8;

    // Traffic shapes on the two channels.
    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } t_pace;

    // A 3x3 frame with the channel extremes and means on both sides of 127.
    localparam logic [IN_TDATA_W-1:0] EDGE_FRAME [9] = '{
        24'h000000, 24'hFFFFFF, 24'h7F7F7F,
        24'h80807F, 24'h808080, 24'hFFFF00,
        24'hFFFFFF, 24'h0000FF, 24'hFFFFFF
    };

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data    = '0;
    logic                         s_axis_tvalid = 1'b0;
    wire logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]        s_axis_tdata  = '0;
    logic                         s_axis_tuser  = 1'b0;
    wire logic                    m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    wire logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    wire logic                    m_axis_tlast;

    int awaited;
    int mismatches;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int thr_now    = THR_RESET;
    int pixels_sent = 0;
    int cycle_count = 0;

    binarize_and_erode_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bae_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_tvalid (s_axis_tvalid),
        .i_pix_tready (s_axis_tready),
        .i_pix_tdata  (s_axis_tdata),
        .i_pix_tuser  (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_res_tlast  (m_axis_tlast),
        .o_awaited    (awaited),
        .o_mismatches (mismatches)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL binarize_and_erode_3x3");
            $finish;
        end
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL: begin
                gap_pct = 0;
                stall_pct <= 0;
            end
            PACE_SENDER_IDLE: begin
                gap_pct = 54;
                stall_pct <= 0;
            end
            PACE_RECEIVER_STALL: begin
                gap_pct = 0;
                stall_pct <= 54;
            end
            default: begin
                gap_pct = 20;
                stall_pct <= 20;
            end
        endcase
    endtask

    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_THRESHOLD)
            thr_now = value & 8'hFF;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned thr, input int unsigned mask);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_ELEMENT_MASK, mask);
    endtask

    // Pixels: plain noise, gray right around the threshold, or pure black and white.
    function automatic logic [IN_TDATA_W-1:0] make_pixel();
        int v;
        case ($urandom_range(3))
            0, 1: return 24'($urandom());
            2: begin
                v = thr_now + int'($urandom_range(2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                return {3{8'(v)}};
            end
            default: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        endcase
    endfunction

    // One pixel request, with random idle cycles ahead of it.
    task automatic send_pixel(input logic [IN_TDATA_W-1:0] rgb, input bit start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rgb;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input bit start);
        for (int k = 0; k < count; k++)
            send_pixel(make_pixel(), start && (k == 0));
    endtask

    // Let every owed result arrive and the pipeline run empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int w;
        int h;
        int thr;
        int mask;
        int frames;
        int n;
        int phase;
        int first_random;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest full frame: channel extremes and means at the threshold.
        set_pace(PACE_FULL);
        configure(3, 3, 127, MASK_RESET);
        for (int k = 0; k < 9; k++)
            send_pixel(EDGE_FRAME[k], k == 0);
        settle();

        // Empty mask, and a frame start that cuts the previous frame short.
        set_pace(PACE_BOTH);
        configure(4, 4, 200, 0);
        send_run(3, 1'b1);
        send_run(7, 1'b1);
        settle();

        // Width shrinks under the running frame: the position moves to the next row.
        write_reg(REG_FRAME_WIDTH, 3);
        send_run(3, 1'b0);
        settle();

        // Zero geometry acts as 1x1, and the row count wraps at once.
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        send_run(2, 1'b0);
        settle();

        // Oversized geometry clamps to the memory size.
        write_reg(REG_FRAME_WIDTH, 4095);
        write_reg(REG_FRAME_HEIGHT, 8191);
        send_run(1, 1'b1);
        settle();

        // Random small frames under every traffic shape.
        phase = 0;
        first_random = pixels_sent;
        while (pixels_sent - first_random < RANDOM_PIXELS) begin
            set_pace(t_pace'(phase % 4));
            if ($urandom_range(3) == 0) begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 4);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            case ($urandom_range(5))
                0: thr = 0;
                1: thr = 255;
                default: thr = $urandom_range(255);
            endcase
            case ($urandom_range(5))
                0: mask = 0;
                1: mask = 511;
                default: mask = $urandom_range(511);
            endcase
            configure(w, h, thr, mask);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                n = w * h;
                // Now and then a frame is cut short by the next frame start.
                if ($urandom_range(7) == 0)
                    n = $urandom_range(1, n);
                send_run(n, (f == 0) || ($urandom_range(7) != 0));
            end
            settle();
            phase++;
        end

        if (mismatches == 0)
            $display("PASS binarize_and_erode_3x3");
        else
            $display("FAIL binarize_and_erode_3x3");
        $finish;
    end

endmodule
